// ----- sv/uts_pkg.sv -----
// Package for the UTF-8 text sanitizer: sequencer states, constants,
// emoji glyph table and typographic substitution table.
// No dependencies.
package uts_pkg;

	localparam int EMOJI_FILLED = 116;
	localparam int EMOJI_ENTRIES_DEF = 118;
	localparam logic [15:0] CAPACITY_RST = 16'd256;
	localparam logic [20:0] BAD_CP = 21'h00FFFD;
	localparam logic [20:0] MAX_CP = 21'h10FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BYTE,
		S_LEAD,
		S_EOT,
		S_CP,
		S_SRCH,
		S_SUB,
		S_EMIT,
		S_MARK,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  len;
		logic [31:0] bytes;
	} subst_t;

	typedef struct packed {
		logic [16:0] cp;
		logic [15:0] gl;
	} emo_t;

	function automatic emo_t emoji_rom(input logic [7:0] idx);
		emo_t e;
		case (idx)
			8'd0: e = '{17'h023F0, 16'h8097};   8'd1: e = '{17'h02600, 16'h8685};
			8'd2: e = '{17'h02601, 16'h8382};   8'd3: e = '{17'h02614, 16'h83A9};
			8'd4: e = '{17'h02615, 16'h83B4};   8'd5: e = '{17'h0263A, 16'h8498};
			8'd6: e = '{17'h02665, 16'h8084};   8'd7: e = '{17'h026A1, 16'h83A7};
			8'd8: e = '{17'h026BD, 16'h87A3};   8'd9: e = '{17'h02705, 16'h808C};
			8'd10: e = '{17'h02708, 16'h81B2};  8'd11: e = '{17'h0270C, 16'h899B};
			8'd12: e = '{17'h02714, 16'h808C};  8'd13: e = '{17'h02728, 16'h8085};
			8'd14: e = '{17'h02744, 16'h8B9C};  8'd15: e = '{17'h0274C, 16'h808D};
			8'd16: e = '{17'h0274E, 16'h808D};  8'd17: e = '{17'h02764, 16'h8084};
			8'd18: e = '{17'h02B50, 16'h8085};  8'd19: e = '{17'h1F319, 16'h8686};
			8'd20: e = '{17'h1F31F, 16'h8085};  8'd21: e = '{17'h1F331, 16'h9398};
			8'd22: e = '{17'h1F333, 16'h86BB};  8'd23: e = '{17'h1F354, 16'h8BA7};
			8'd24: e = '{17'h1F355, 16'h8BA7};  8'd25: e = '{17'h1F37A, 16'h83BC};
			8'd26: e = '{17'h1F37B, 16'h83BC};  8'd27: e = '{17'h1F381, 16'h81AB};
			8'd28: e = '{17'h1F382, 16'h87BD};  8'd29: e = '{17'h1F389, 16'h9E9F};
			8'd30: e = '{17'h1F38A, 16'h9E9F};  8'd31: e = '{17'h1F3B5, 16'h8081};
			8'd32: e = '{17'h1F3B6, 16'h8081};  8'd33: e = '{17'h1F3C3, 16'h9C8C};
			8'd34: e = '{17'h1F3C6, 16'h8291};  8'd35: e = '{17'h1F3E0, 16'h8095};
			8'd36: e = '{17'h1F431, 16'h9ABE};  8'd37: e = '{17'h1F436, 16'h9B93};
			8'd38: e = '{17'h1F440, 16'h81AE};  8'd39: e = '{17'h1F446, 16'h82A6};
			8'd40: e = '{17'h1F449, 16'h82A4};  8'd41: e = '{17'h1F44C, 16'h85A4};
			8'd42: e = '{17'h1F44D, 16'h85A4};  8'd43: e = '{17'h1F44E, 16'h85A5};
			8'd44: e = '{17'h1F44F, 16'h9382};  8'd45: e = '{17'h1F47B, 16'h9BA2};
			8'd46: e = '{17'h1F480, 16'h958C};  8'd47: e = '{17'h1F48E, 16'h8EA5};
			8'd48: e = '{17'h1F494, 16'h9EA9};  8'd49: e = '{17'h1F495, 16'h8084};
			8'd50: e = '{17'h1F496, 16'h8084};  8'd51: e = '{17'h1F497, 16'h8084};
			8'd52: e = '{17'h1F499, 16'h8084};  8'd53: e = '{17'h1F49A, 16'h8084};
			8'd54: e = '{17'h1F49B, 16'h8084};  8'd55: e = '{17'h1F49C, 16'h8084};
			8'd56: e = '{17'h1F49E, 16'h8084};  8'd57: e = '{17'h1F4A3, 16'h87A2};
			8'd58: e = '{17'h1F4A9, 16'h8BBE};  8'd59: e = '{17'h1F4AA, 16'h918B};
			8'd60: e = '{17'h1F4CD, 16'h8F85};  8'd61: e = '{17'h1F4DE, 16'h8295};
			8'd62: e = '{17'h1F4E7, 16'h83A0};  8'd63: e = '{17'h1F4F7, 16'h80B0};
			8'd64: e = '{17'h1F525, 16'h81AD};  8'd65: e = '{17'h1F600, 16'h9680};
			8'd66: e = '{17'h1F601, 16'h9682};  8'd67: e = '{17'h1F602, 16'h9688};
			8'd68: e = '{17'h1F603, 16'h9680};  8'd69: e = '{17'h1F604, 16'h9682};
			8'd70: e = '{17'h1F605, 16'h9683};  8'd71: e = '{17'h1F606, 16'h969B};
			8'd72: e = '{17'h1F609, 16'h968C};  8'd73: e = '{17'h1F60A, 16'h96B8};
			8'd74: e = '{17'h1F60B, 16'h9689};  8'd75: e = '{17'h1F60D, 16'h9684};
			8'd76: e = '{17'h1F60E, 16'h9680};  8'd77: e = '{17'h1F60F, 16'h939A};
			8'd78: e = '{17'h1F610, 16'h849A};  8'd79: e = '{17'h1F611, 16'h96A4};
			8'd80: e = '{17'h1F614, 16'h8499};  8'd81: e = '{17'h1F615, 16'h95BA};
			8'd82: e = '{17'h1F617, 16'h9696};  8'd83: e = '{17'h1F618, 16'h9696};
			8'd84: e = '{17'h1F61B, 16'h9689};  8'd85: e = '{17'h1F61C, 16'h968B};
			8'd86: e = '{17'h1F61E, 16'h95BA};  8'd87: e = '{17'h1F620, 16'h9596};
			8'd88: e = '{17'h1F621, 16'h9596};  8'd89: e = '{17'h1F622, 16'h96B4};
			8'd90: e = '{17'h1F629, 16'h9788};  8'd91: e = '{17'h1F62B, 16'h9788};
			8'd92: e = '{17'h1F62C, 16'h95BF};  8'd93: e = '{17'h1F62D, 16'h96B3};
			8'd94: e = '{17'h1F62E, 16'h9782};  8'd95: e = '{17'h1F631, 16'h9782};
			8'd96: e = '{17'h1F633, 16'h95B9};  8'd97: e = '{17'h1F634, 16'h88B6};
			8'd98: e = '{17'h1F635, 16'h95A7};  8'd99: e = '{17'h1F641, 16'h8499};
			8'd100: e = '{17'h1F642, 16'h8498}; 8'd101: e = '{17'h1F644, 16'h96A5};
			8'd102: e = '{17'h1F64F, 16'h9A84}; 8'd103: e = '{17'h1F680, 16'h84B5};
			8'd104: e = '{17'h1F697, 16'h86B9}; 8'd105: e = '{17'h1F6D2, 16'h81BA};
			8'd106: e = '{17'h1F917, 16'h96B8}; 8'd107: e = '{17'h1F923, 16'h9686};
			8'd108: e = '{17'h1F926, 16'h9788}; 8'd109: e = '{17'h1F929, 16'h9687};
			8'd110: e = '{17'h1F937, 16'h849A}; 8'd111: e = '{17'h1F942, 16'h9E9F};
			8'd112: e = '{17'h1F970, 16'h9684}; 8'd113: e = '{17'h1F973, 16'h9687};
			8'd114: e = '{17'h1F97A, 16'h96B4}; 8'd115: e = '{17'h1F9E1, 16'h8084};
			default: e = '{17'h1FFFF, 16'h0000};
		endcase
		return e;
	endfunction

	// bytes are packed first byte lowest
	function automatic subst_t typo_sub(input logic [20:0] cp);
		subst_t s;
		s = '{1'b1, 3'd1, 32'h0};
		case (cp)
			21'h2018, 21'h2019, 21'h201B, 21'h2032: s.bytes = 32'h27;
			21'h201C, 21'h201D, 21'h201F, 21'h2033: s.bytes = 32'h22;
			21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014,
			21'h2015, 21'h2212: s.bytes = 32'h2D;
			21'h2026: begin
				s.len = 3'd3;
				s.bytes = 32'h2E2E2E;
			end
			21'h2000, 21'h2001, 21'h2002, 21'h2003, 21'h2007,
			21'h2009, 21'h200A, 21'h202F: s.bytes = 32'h20;
			21'h200B, 21'h200C, 21'h200D, 21'h0FEFF: s.len = 3'd0;
			21'h2039: s.bytes = 32'h3C;
			21'h203A: s.bytes = 32'h3E;
			21'h2044: s.bytes = 32'h2F;
			21'h2122: begin
				s.len = 3'd4;
				s.bytes = 32'h294D5428;
			end
			21'h2192: begin
				s.len = 3'd2;
				s.bytes = 32'h3E2D;
			end
			21'h2190: begin
				s.len = 3'd2;
				s.bytes = 32'h2D3C;
			end
			21'h2713: begin
				s.len = 3'd2;
				s.bytes = 32'h4B4F;
			end
			default: s = '{1'b0, 3'd0, 32'h0};
		endcase
		return s;
	endfunction

endpackage

// ----- sv/utf8_text_sanitizer.sv -----
// Top level of the UTF-8 text sanitizer: decoder, sequencer, emoji bisection
// and output register. Depends on uts_pkg.
// The emoji bisection probes one table entry a cycle (up to 7 probes), and the
// bytes of each result go out one at a time. One input transaction is handled
// at a time; s_tready is high only while the sequencer is idle. The last result
// of a transaction waits in a pending register until the flush state moves it
// to the output register.
// Reset: arst_n clears the decoder, length count, stop and pending flags and loads out_capacity with 256.
module utf8_text_sanitizer #(
	parameter int EMOJI_ENTRIES = uts_pkg::EMOJI_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte [7:0], total_length [23:8]
	output logic [1:0]  m_tuser,   // has_out_byte [0], text_done [1]
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // out_capacity
);

	localparam int SPAN = (EMOJI_ENTRIES < uts_pkg::EMOJI_FILLED) ?
		EMOJI_ENTRIES : uts_pkg::EMOJI_FILLED;
	localparam int IW = $clog2(SPAN + 1);

	uts_pkg::state_t state_q, state_d, ret_q;

	logic [15:0] cap_q, wc_q;
	logic [20:0] acc_q, cp_q;
	logic [2:0]  exp_q, rec_q, len_q, idx_q;
	logic        lwr_q, stop_q;
	logic [7:0]  byte_q;
	logic        has_q, eot_q;
	logic [7:0]  buf_q [4];
	logic [IW-1:0] lo_q, hi_q;
	logic        pend_v_q;
	logic [25:0] pend_q;
	logic        m_tvalid_q, m_tlast_q;
	logic [23:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic        can_push, put_go, flush_go;
	logic        is_cont, seq_open, closing, bad_close, full;
	logic [20:0] acc_next;
	logic [2:0]  rec_next;
	logic [15:0] room;
	logic        ctrl, font, empty_sub;
	logic [2:0]  enc_len;
	logic [7:0]  enc [3];
	logic [IW-1:0] mid;
	uts_pkg::emo_t  ent;
	uts_pkg::subst_t sub;

	assign s_tready = (state_q == uts_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	assign can_push = !m_tvalid_q || m_tready;

	assign is_cont = (byte_q[7:6] == 2'b10);
	assign seq_open = (exp_q != 3'd0);
	assign acc_next = {acc_q[14:0], byte_q[5:0]};
	assign rec_next = rec_q + 3'd1;
	assign closing = (rec_next >= exp_q);
	assign bad_close = (exp_q == 3'd2 && acc_next < 21'h80) ||
		(exp_q == 3'd3 && acc_next < 21'h800) ||
		(exp_q == 3'd4 && acc_next < 21'h10000) ||
		(acc_next >= 21'h0D800 && acc_next <= 21'h0DFFF) ||
		(acc_next > uts_pkg::MAX_CP);
	assign full = ({1'b0, wc_q} + 17'd1) >= {1'b0, cap_q};
	assign room = cap_q - 16'd1 - wc_q;

	assign ctrl = (cp_q < 21'h20 && cp_q != 21'h0A) || cp_q == 21'h7F;
	assign font = cp_q == 21'h0A || (cp_q >= 21'h20 && cp_q <= 21'h7E) ||
		(cp_q >= 21'hA0 && cp_q <= 21'hFF) || cp_q == 21'h2022 || cp_q == 21'h20AC;
	assign empty_sub = cp_q == 21'hFE0E || cp_q == 21'hFE0F || cp_q == 21'h20E3 ||
		(cp_q >= 21'h1F3FB && cp_q <= 21'h1F3FF);

	always_comb begin
		enc[0] = cp_q[7:0];
		enc[1] = 8'h00;
		enc[2] = 8'h00;
		enc_len = 3'd1;
		if (cp_q >= 21'h800) begin
			enc[0] = {4'hE, cp_q[15:12]};
			enc[1] = {2'b10, cp_q[11:6]};
			enc[2] = {2'b10, cp_q[5:0]};
			enc_len = 3'd3;
		end else if (cp_q >= 21'h80) begin
			enc[0] = {3'b110, cp_q[10:6]};
			enc[1] = {2'b10, cp_q[5:0]};
			enc_len = 3'd2;
		end
	end

	assign mid = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign ent = uts_pkg::emoji_rom(8'(mid));
	assign sub = uts_pkg::typo_sub(cp_q);

	always_comb begin
		state_d = state_q;
		put_go = 1'b0;
		flush_go = 1'b0;
		case (state_q)
			uts_pkg::S_IDLE: if (s_tvalid) state_d = uts_pkg::S_BYTE;
			uts_pkg::S_BYTE: begin
				if (!has_q) state_d = uts_pkg::S_EOT;
				else if (seq_open && is_cont) state_d = closing ? uts_pkg::S_CP : uts_pkg::S_EOT;
				else if (seq_open) state_d = uts_pkg::S_CP;
				else state_d = uts_pkg::S_LEAD;
			end
			uts_pkg::S_LEAD: begin
				if (byte_q[7] && (byte_q[7:5] == 3'b110 || byte_q[7:4] == 4'b1110 ||
						byte_q[7:3] == 5'b11110))
					state_d = uts_pkg::S_EOT;
				else state_d = uts_pkg::S_CP;
			end
			uts_pkg::S_EOT: begin
				if (!eot_q) state_d = uts_pkg::S_FLUSH;
				else if (seq_open) state_d = uts_pkg::S_CP;
				else state_d = uts_pkg::S_MARK;
			end
			uts_pkg::S_CP: begin
				if (stop_q || full || ctrl) state_d = ret_q;
				else if (font) state_d = ({13'd0, enc_len} > room) ? ret_q : uts_pkg::S_EMIT;
				else if (empty_sub) state_d = ret_q;
				else state_d = uts_pkg::S_SRCH;
			end
			uts_pkg::S_SRCH: begin
				if (lo_q >= hi_q) state_d = uts_pkg::S_SUB;
				else if ({4'd0, ent.cp} == cp_q)
					state_d = (room < 16'd3) ? ret_q : uts_pkg::S_EMIT;
			end
			uts_pkg::S_SUB: begin
				if (sub.hit) begin
					if (sub.len == 3'd0 || {13'd0, sub.len} > room) state_d = ret_q;
					else state_d = uts_pkg::S_EMIT;
				end else if (lwr_q || room < 16'd3) state_d = ret_q;
				else state_d = uts_pkg::S_EMIT;
			end
			uts_pkg::S_EMIT: begin
				put_go = !pend_v_q || can_push;
				if (put_go && idx_q == len_q - 3'd1) state_d = ret_q;
			end
			uts_pkg::S_MARK: begin
				put_go = !pend_v_q || can_push;
				if (put_go) state_d = uts_pkg::S_FLUSH;
			end
			uts_pkg::S_FLUSH: begin
				flush_go = pend_v_q && can_push;
				if (!pend_v_q || can_push) state_d = uts_pkg::S_IDLE;
			end
			default: state_d = uts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= uts_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= uts_pkg::CAPACITY_RST;
			wc_q <= '0;
			acc_q <= '0;
			exp_q <= '0;
			rec_q <= '0;
			lwr_q <= 1'b0;
			stop_q <= 1'b0;
			pend_v_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			ret_q <= uts_pkg::S_IDLE;
		end else begin
			if (cfg_valid) cap_q <= cfg_data;
			if ((put_go || flush_go) && pend_v_q) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q <= pend_q[23:0];
				m_tuser_q <= pend_q[25:24];
				m_tlast_q <= flush_go;
			end else if (m_tready) m_tvalid_q <= 1'b0;
			if (flush_go) pend_v_q <= 1'b0;
			case (state_q)
				uts_pkg::S_IDLE: if (s_tvalid) begin
					byte_q <= s_tdata;
					has_q <= s_tuser;
					eot_q <= s_tlast;
				end
				uts_pkg::S_BYTE: if (has_q && seq_open) begin
					if (is_cont) begin
						if (closing) begin
							cp_q <= bad_close ? uts_pkg::BAD_CP : acc_next;
							exp_q <= '0;
							rec_q <= '0;
							acc_q <= '0;
							ret_q <= uts_pkg::S_EOT;
						end else begin
							acc_q <= acc_next;
							rec_q <= rec_next;
						end
					end else begin
						cp_q <= uts_pkg::BAD_CP;
						exp_q <= '0;
						rec_q <= '0;
						acc_q <= '0;
						ret_q <= uts_pkg::S_LEAD;
					end
				end
				uts_pkg::S_LEAD: begin
					ret_q <= uts_pkg::S_EOT;
					rec_q <= 3'd1;
					if (!byte_q[7]) cp_q <= {13'd0, byte_q};
					else if (byte_q[7:5] == 3'b110) begin
						exp_q <= 3'd2;
						acc_q <= {16'd0, byte_q[4:0]};
					end else if (byte_q[7:4] == 4'b1110) begin
						exp_q <= 3'd3;
						acc_q <= {17'd0, byte_q[3:0]};
					end else if (byte_q[7:3] == 5'b11110) begin
						exp_q <= 3'd4;
						acc_q <= {18'd0, byte_q[2:0]};
					end else cp_q <= uts_pkg::BAD_CP;
				end
				uts_pkg::S_EOT: if (eot_q && seq_open) begin
					cp_q <= uts_pkg::BAD_CP;
					exp_q <= '0;
					rec_q <= '0;
					acc_q <= '0;
					ret_q <= uts_pkg::S_MARK;
				end
				uts_pkg::S_CP: begin
					idx_q <= '0;
					lo_q <= '0;
					hi_q <= IW'(SPAN);
					if (!stop_q) begin
						if (full) stop_q <= 1'b1;
						else if (!ctrl && font) begin
							lwr_q <= 1'b0;
							if ({13'd0, enc_len} > room) stop_q <= 1'b1;
							buf_q[0] <= enc[0];
							buf_q[1] <= enc[1];
							buf_q[2] <= enc[2];
							len_q <= enc_len;
						end else if (!ctrl && empty_sub) lwr_q <= 1'b0;
					end
				end
				uts_pkg::S_SRCH: if (lo_q < hi_q) begin
					if ({4'd0, ent.cp} == cp_q) begin
						lwr_q <= 1'b0;
						if (room < 16'd3) stop_q <= 1'b1;
						buf_q[0] <= 8'hEF;
						buf_q[1] <= ent.gl[15:8];
						buf_q[2] <= ent.gl[7:0];
						len_q <= 3'd3;
					end else if ({4'd0, ent.cp} < cp_q) lo_q <= mid + IW'(1);
					else hi_q <= mid;
				end
				uts_pkg::S_SUB: begin
					if (sub.hit) begin
						lwr_q <= 1'b0;
						if ({13'd0, sub.len} > room) stop_q <= 1'b1;
						buf_q[0] <= sub.bytes[7:0];
						buf_q[1] <= sub.bytes[15:8];
						buf_q[2] <= sub.bytes[23:16];
						buf_q[3] <= sub.bytes[31:24];
						len_q <= sub.len;
					end else if (!lwr_q) begin
						if (room < 16'd3) stop_q <= 1'b1;
						else lwr_q <= 1'b1;
						buf_q[0] <= 8'hE2;
						buf_q[1] <= 8'h80;
						buf_q[2] <= 8'hA2;
						len_q <= 3'd3;
					end
				end
				uts_pkg::S_EMIT: if (put_go) begin
					pend_v_q <= 1'b1;
					pend_q <= {2'b01, wc_q + 16'd1, buf_q[idx_q[1:0]]};
					wc_q <= wc_q + 16'd1;
					idx_q <= idx_q + 3'd1;
				end
				uts_pkg::S_MARK: if (put_go) begin
					pend_v_q <= 1'b1;
					pend_q <= {2'b10, wc_q, 8'h00};
					wc_q <= '0;
					acc_q <= '0;
					exp_q <= '0;
					rec_q <= '0;
					lwr_q <= 1'b0;
					stop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/uts_checker.sv -----
// Port-level checks for the UTF-8 text sanitizer, bound to the top level.
// Depends on utf8_text_sanitizer's port list only.
module uts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("end marker not last or carries text");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[7:0] == 8'h00)
		else $error("end marker byte not zero");

endmodule

bind utf8_text_sanitizer uts_checker u_uts_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);
